// ===== rtl/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, codes and the CRC-32 byte update for the chunk deframer.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam int unsigned BITS_PER_BYTE = 8;

  typedef enum logic [2:0] {
    PH_SEQ  = 3'd0,
    PH_LEN  = 3'd1,
    PH_BODY = 3'd2,
    PH_CRC  = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_SHORT    = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_TOOBIG   = 3'd4
  } status_e;

  typedef struct packed {
    logic               kind;
    logic [7:0]         payload_byte;
    logic signed [31:0] sequence_number;
    logic [31:0]        payload_length;
    logic [31:0]        trailer_crc;
    logic               crc_match;
    status_e            status;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/chd_parser.sv =====
// ----------------------------------------------------------------------------
// chd_parser
// Header, body and trailer parsing with running CRC; builds up to two results
// for every accepted byte.
// ----------------------------------------------------------------------------
module chd_parser import chd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_buffer_i,
  input  logic [30:0] max_len_i,
  output push_t       push_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] byte_cnt_q, byte_cnt_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] len_q, len_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] fld_q, fld_d;

  logic [31:0] total;
  logic        pay_v, st_v, st_done;
  status_e     st_code;
  result_t     pay_r, st_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEQ;
      byte_cnt_q <= '0;
      seq_q      <= '0;
      len_q      <= '0;
      acc_q      <= CRC_ONES;
      fld_q      <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      seq_q      <= seq_d;
      len_q      <= len_d;
      acc_q      <= acc_d;
      fld_q      <= fld_d;
    end
  end

  always_comb begin
    total   = (byte_cnt_q == CRC_ONES) ? byte_cnt_q : byte_cnt_q + 32'd1;
    phase_d = phase_q;
    seq_d   = seq_q;
    len_d   = len_q;
    acc_d   = acc_q;
    fld_d   = fld_q;
    pay_v   = 1'b0;
    st_v    = 1'b0;
    st_done = 1'b0;
    st_code = ST_OK;

    case (phase_q)
      PH_SEQ: begin
        seq_d = {seq_q[23:0], in_byte_i};
        if (byte_cnt_q >= 32'd3) phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = {len_q[23:0], in_byte_i};
        if (byte_cnt_q >= 32'd7) begin
          if (len_d > {1'b0, max_len_i}) begin
            phase_d = PH_DONE;
            if (!end_of_buffer_i) begin
              st_v    = 1'b1;
              st_done = 1'b1;
              st_code = ST_TOOBIG;
            end
          end else begin
            phase_d = (len_d == '0) ? PH_CRC : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        pay_v = 1'b1;
        acc_d = crc32_byte(acc_q, in_byte_i);
        if ({1'b0, byte_cnt_q} >= {1'b0, len_q} + 33'd7) phase_d = PH_CRC;
      end
      PH_CRC: begin
        fld_d = {fld_q[23:0], in_byte_i};
        if ({1'b0, byte_cnt_q} >= {1'b0, len_q} + 33'd11) begin
          st_v    = 1'b1;
          st_done = 1'b1;
          st_code = ((acc_q ^ CRC_ONES) == fld_d) ? ST_OK : ST_MISMATCH;
          phase_d = PH_DONE;
        end
      end
      default: phase_d = PH_DONE;
    endcase

    byte_cnt_d = total;

    if (end_of_buffer_i && !st_done && phase_q != PH_DONE) begin
      st_v    = 1'b1;
      st_code = (total < 32'd12) ? ST_SHORT : ST_TRUNC;
    end

    pay_r                 = '0;
    pay_r.payload_byte    = in_byte_i;
    pay_r.status          = ST_OK;
    pay_r.last_of_run     = !st_v;

    st_r                  = '0;
    st_r.kind             = 1'b1;
    st_r.sequence_number  = (total >= 32'd4) ? seq_d : '0;
    st_r.payload_length   = (total >= 32'd8) ? len_d : '0;
    st_r.trailer_crc      = (st_code == ST_OK || st_code == ST_MISMATCH) ? fld_d : '0;
    st_r.crc_match        = (st_code == ST_OK);
    st_r.status           = st_code;
    st_r.last_of_run      = 1'b1;

    if (end_of_buffer_i) begin
      phase_d    = PH_SEQ;
      byte_cnt_d = '0;
      seq_d      = '0;
      len_d      = '0;
      acc_d      = CRC_ONES;
      fld_d      = '0;
    end

    push_o.count  = accept_i ? ({1'b0, pay_v} + {1'b0, st_v}) : 2'd0;
    push_o.first  = pay_v ? pay_r : st_r;
    push_o.second = st_r;
  end

endmodule

// ===== rtl/chd_out_queue.sv =====
// ----------------------------------------------------------------------------
// chd_out_queue
// Small result queue taking up to two results per cycle and handing out one when not stalled.
// ----------------------------------------------------------------------------
module chd_out_queue import chd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    stall_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] THRESH   = CW'(DEPTH - 2);

  result_t       mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q > THRESH);
  assign pop     = valid_o && !stall_i;

  always_comb begin
    wr_nxt = (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
    case (push_i.count)
      2'd1:    wr_d = wr_nxt;
      2'd2:    wr_d = (wr_nxt == LAST_PTR) ? '0 : wr_nxt + PW'(1);
      default: wr_d = wr_q;
    endcase
    rd_d  = pop ? ((rd_q == LAST_PTR) ? '0 : rd_q + PW'(1)) : rd_q;
    cnt_d = cnt_q + CW'(push_i.count) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_nxt] <= push_i.second;
  end

endmodule

// ===== rtl/chunk_deframer_crc32_check_unit.sv =====
// ----------------------------------------------------------------------------
// chunk_deframer_crc32_check_unit
// Chunk deframer: header parse, payload forward, trailing CRC-32 check.
// ----------------------------------------------------------------------------
// One chunk byte is taken per cycle, back to back, and its CRC-32 update and
// field capture finish in that same cycle. Every byte yields zero, one or two
// results (a body byte that ends the buffer gives the payload byte and then
// the short or truncation status); these go to an OUT_DEPTH-entry result queue
// that drains one result per cycle when not stalled. Input is stalled only while
// the queue cannot take two more results, so the sustained rate is one byte per
// cycle unless the output side stalls. The max_payload_len register sits at address 0.
module chunk_deframer_crc32_check_unit import chd_pkg::*; #(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_buffer_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_kind_o,
  output logic [7:0]         payload_byte_o,
  output logic signed [31:0] sequence_number_o,
  output logic [31:0]        payload_length_o,
  output logic [31:0]        trailer_crc_o,
  output logic               crc_match_o,
  output logic [2:0]         status_o,
  output logic               last_of_run_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic REG_MAX_LEN = 1'b0;

  logic [30:0] max_len_q, max_len_d;
  logic        in_acc, cfg_wr;
  push_t       push;
  result_t     res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LEN);
  assign max_len_d = cfg_wr ? pwdata[30:0] : max_len_q;
  assign prdata = (paddr[2] == REG_MAX_LEN) ? {1'b0, max_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 31'd8192;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign in_acc = in_valid_i && !in_stall_o;

  chd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_acc),
    .in_byte_i       (in_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .max_len_i       (max_len_q),
    .push_o          (push)
  );

  chd_out_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (res),
    .full_o  (in_stall_o)
  );

  assign out_kind_o        = res.kind;
  assign payload_byte_o    = res.payload_byte;
  assign sequence_number_o = res.sequence_number;
  assign payload_length_o  = res.payload_length;
  assign trailer_crc_o     = res.trailer_crc;
  assign crc_match_o       = res.crc_match;
  assign status_o          = res.status;
  assign last_of_run_o     = res.last_of_run;

endmodule

// ===== rtl/chd_checker.sv =====
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks for the chunk deframer, bound to the top level.
// ----------------------------------------------------------------------------
module chd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [2:0]  status_o,
  input logic        last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o)
      && $stable(payload_byte_o) && $stable(status_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result appeared without an input transfer");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an input transfer");

  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o && out_kind_o)
    else $error("status result missing after payload result");

endmodule

bind chunk_deframer_crc32_check_unit chd_checker u_chd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_kind_o     (out_kind_o),
  .payload_byte_o (payload_byte_o),
  .status_o       (status_o),
  .last_of_run_o  (last_of_run_o)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chunk deframer with CRC-32 check. Chunks are
// built as byte streams (good, corrupted CRC, cut short, oversized length,
// noise), pushed through the byte channel with random gaps and output stalls,
// and every result transfer is compared with a local parser prediction.
// ----------------------------------------------------------------------------
module testbench;
  import chd_pkg::*;

  localparam logic [2:0]  ADDR_MAX_LEN = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED  = 3'd4;
  localparam int unsigned BYTES_PER_SETTING = 270;
  localparam int unsigned HOLD_AT     = 600;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0] data;
    logic       eob;
  } chunk_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [7:0]         in_byte = 8'h00;
  logic               in_eob = 1'b0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic               out_kind_o;
  logic [7:0]         payload_byte_o;
  logic signed [31:0] sequence_number_o;
  logic [31:0]        payload_length_o;
  logic [31:0]        trailer_crc_o;
  logic               crc_match_o;
  logic [2:0]         status_o;
  logic               last_of_run_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = 3'd0;
  logic [31:0]        pwdata = 32'h0;
  logic [31:0]        prdata;
  logic               pready;

  chunk_deframer_crc32_check_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .in_byte_i         (in_byte),
    .end_of_buffer_i   (in_eob),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .out_kind_o        (out_kind_o),
    .payload_byte_o    (payload_byte_o),
    .sequence_number_o (sequence_number_o),
    .payload_length_o  (payload_length_o),
    .trailer_crc_o     (trailer_crc_o),
    .crc_match_o       (crc_match_o),
    .status_o          (status_o),
    .last_of_run_o     (last_of_run_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk_i = ~clk_i;

  // parser prediction state
  logic [30:0] cfg_max = 31'd8192;
  phase_e      prd_phase;
  logic [31:0] prd_count;
  logic [31:0] prd_seq;
  logic [31:0] prd_len;
  logic [31:0] prd_crc;
  logic [31:0] prd_crc_rx;

  chunk_byte_t pending_bytes[$];
  result_t     expected_results[$];
  logic [7:0]  frame_buf[$];

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_predicted = 0;
  int unsigned n_checked = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_chunks = 0;
  int unsigned n_settings = 0;
  int unsigned stat_seen[8];
  int unsigned gap_pct = 31;
  int unsigned stall_pct = 31;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_cnt = 0;

  function automatic logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic void parser_rearm();
    prd_phase  = PH_SEQ;
    prd_count  = '0;
    prd_seq    = '0;
    prd_len    = '0;
    prd_crc    = CRC_ONES;
    prd_crc_rx = '0;
  endfunction

  function automatic result_t status_item(status_e st, logic [31:0] total);
    result_t r;
    r = '0;
    r.kind            = 1'b1;
    r.sequence_number = (total >= 4) ? prd_seq : '0;
    r.payload_length  = (total >= 8) ? prd_len : '0;
    r.trailer_crc     = (st == ST_OK || st == ST_MISMATCH) ? prd_crc_rx : '0;
    r.crc_match       = (st == ST_OK);
    r.status          = st;
    return r;
  endfunction

  function automatic int deframe_byte(logic [7:0] b, logic eob);
    logic [31:0] pos;
    logic [31:0] total;
    phase_e      prior;
    bit          closed;
    result_t     outs[$];
    result_t     r;
    pos    = prd_count;
    total  = (pos == CRC_ONES) ? pos : pos + 32'd1;
    prior  = prd_phase;
    closed = 1'b0;
    prd_count = total;
    case (prior)
      PH_SEQ: begin
        prd_seq = {prd_seq[23:0], b};
        if (pos >= 3) prd_phase = PH_LEN;
      end
      PH_LEN: begin
        prd_len = {prd_len[23:0], b};
        if (pos >= 7) begin
          if (prd_len > {1'b0, cfg_max}) begin
            prd_phase = PH_DONE;
            if (!eob) begin
              outs.push_back(status_item(ST_TOOBIG, total));
              closed = 1'b1;
            end
          end else begin
            prd_phase = (prd_len == 0) ? PH_CRC : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        r = '0;
        r.payload_byte = b;
        outs.push_back(r);
        prd_crc = crc_step(prd_crc, b);
        if ({1'b0, pos} >= {1'b0, prd_len} + 33'd7) prd_phase = PH_CRC;
      end
      PH_CRC: begin
        prd_crc_rx = {prd_crc_rx[23:0], b};
        if ({1'b0, pos} >= {1'b0, prd_len} + 33'd11) begin
          outs.push_back(status_item(((prd_crc ^ CRC_ONES) == prd_crc_rx) ?
                                     ST_OK : ST_MISMATCH, total));
          closed    = 1'b1;
          prd_phase = PH_DONE;
        end
      end
      default: prd_phase = PH_DONE;
    endcase
    if (eob) begin
      if (!closed && prior != PH_DONE)
        outs.push_back(status_item((total < 12) ? ST_SHORT : ST_TRUNC, total));
      parser_rearm();
    end
    if (outs.size() != 0) outs[outs.size() - 1].last_of_run = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
    return outs.size();
  endfunction

  function automatic void flag_mismatch(string msg);
    if (n_mismatch < 10) $display("MISMATCH %s", msg);
    n_mismatch++;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("kind=%0d byte=%02h seq=%08h len=%08h crc=%08h match=%0d st=%0d last=%0d",
                     r.kind, r.payload_byte, r.sequence_number, r.payload_length,
                     r.trailer_crc, r.crc_match, r.status, r.last_of_run);
  endfunction

  // byte channel driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    chunk_byte_t nxt;
    int          cnt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      parser_rearm();
    end else begin
      if (in_valid && !in_stall_o) begin
        cnt = deframe_byte(in_byte, in_eob);
        n_predicted <= n_predicted + cnt;
        n_accepted  <= n_accepted + 1;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.data;
          in_eob   <= nxt.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : check
    result_t act;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      act = '0;
      act.kind            = out_kind_o;
      act.payload_byte    = payload_byte_o;
      act.sequence_number = sequence_number_o;
      act.payload_length  = payload_length_o;
      act.trailer_crc     = trailer_crc_o;
      act.crc_match       = crc_match_o;
      act.status          = status_e'(status_o);
      act.last_of_run     = last_of_run_o;
      if (out_kind_o) stat_seen[status_o]++;
      n_checked <= n_checked + 1;
      if (expected_results.size() == 0) begin
        flag_mismatch({"unexpected result ", fmt_result(act)});
      end else begin
        want = expected_results.pop_front();
        if (act.kind !== want.kind || act.payload_byte !== want.payload_byte ||
            act.sequence_number !== want.sequence_number ||
            act.payload_length !== want.payload_length ||
            act.trailer_crc !== want.trailer_crc || act.crc_match !== want.crc_match ||
            act.status !== want.status || act.last_of_run !== want.last_of_run)
          flag_mismatch({"expected ", fmt_result(want), " got ", fmt_result(act)});
      end
    end
  end

  // output stall, with one long hold-off while input is still pending
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT && n_queued - n_accepted > 40) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAX_LEN) cfg_max = data[30:0];
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      flag_mismatch($sformatf("register read expected %08h got %08h", want, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || n_checked != n_predicted) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic eob);
    chunk_byte_t cb;
    cb.data = data;
    cb.eob  = eob;
    pending_bytes.push_back(cb);
    n_queued++;
  endtask

  task automatic frame_head(input logic [31:0] seq, input logic [31:0] len);
    frame_buf.delete();
    for (int i = 3; i >= 0; i--) frame_buf.push_back(seq[8*i +: 8]);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(len[8*i +: 8]);
  endtask

  task automatic frame_body(input int unsigned len, input bit corrupt);
    logic [7:0]  b;
    logic [31:0] c;
    c = CRC_ONES;
    for (int unsigned k = 0; k < len; k++) begin
      b = 8'($urandom);
      frame_buf.push_back(b);
      c = crc_step(c, b);
    end
    c = c ^ CRC_ONES;
    if (corrupt) c = c ^ (32'h1 << $urandom_range(31));
    for (int i = 3; i >= 0; i--) frame_buf.push_back(c[8*i +: 8]);
  endtask

  // keep bytes of the built frame, then junk bytes; end of buffer on the last
  task automatic emit(input int unsigned keep, input int unsigned junk);
    for (int unsigned i = 0; i < keep; i++)
      push_byte(frame_buf[i], junk == 0 && i == keep - 1);
    for (int unsigned j = 0; j < junk; j++)
      push_byte(8'($urandom), j == junk - 1);
    n_chunks++;
  endtask

  task automatic random_chunk();
    int unsigned pick;
    int unsigned len;
    int unsigned cap;
    int unsigned n;
    logic [31:0] big;
    pick = $urandom_range(99);
    cap  = (cfg_max < 16) ? int'(cfg_max) : 16;
    len  = $urandom_range(cap);
    if ($urandom_range(19) == 0) len = (cfg_max < 160) ? int'(cfg_max) : $urandom_range(160, 40);
    if (pick < 67) begin
      frame_head($urandom, len);
      frame_body(len, pick >= 55);
      emit(frame_buf.size(), ($urandom_range(9) < 3) ? $urandom_range(3, 1) : 0);
    end else if (pick < 82) begin
      frame_head($urandom, len);
      frame_body(len, 1'($urandom_range(1)));
      emit($urandom_range(frame_buf.size() - 1, 1), 0);
    end else if (pick < 92) begin
      if ($urandom_range(3) == 0) begin
        big = {1'b0, cfg_max} + 32'd1;
      end else begin
        big = $urandom;
        while (big <= {1'b0, cfg_max}) big = $urandom;
      end
      frame_head($urandom, big);
      emit(8, $urandom_range(4));
    end else begin
      n = $urandom_range(6, 1);
      for (int unsigned i = 0; i < n; i++)
        push_byte(8'($urandom), (i == n - 1) || ($urandom_range(3) == 0));
      n_chunks++;
    end
  endtask

  initial begin : stimulus
    logic [31:0] settings[6];
    int unsigned start;
    settings[0] = 32'hFFFF_FFFF;
    settings[1] = 32'd0;
    settings[2] = 32'd8192;
    settings[3] = 32'd3;
    settings[4] = $urandom_range(40);
    settings[5] = $urandom;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_read_check(ADDR_MAX_LEN, {1'b0, cfg_max});
    n_settings++;
    @(negedge clk_i);

    // zero-length good chunk, oversized length, early end on the length byte
    frame_head(32'h8000_0000, 32'd0);
    frame_body(0, 1'b0);
    emit(12, 0);
    frame_head($urandom, 32'd8193);
    emit(8, 1);
    frame_head(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    emit(8, 0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      apb_write(ADDR_MAX_LEN, settings[p]);
      if (p == 2) apb_write(ADDR_UNUSED, $urandom);
      apb_read_check(ADDR_MAX_LEN, {1'b0, cfg_max});
      n_settings++;
      @(negedge clk_i);
      gap_pct   = (p == 3) ? 0 : 31;
      stall_pct = (p == 3) ? 0 : 31;
      start = n_queued;
      while (n_queued - start < BYTES_PER_SETTING) random_chunk();
      wait_drained();
    end

    $display("covered %0d chunks, %0d bytes, %0d results over %0d length limits",
             n_chunks, n_accepted, n_checked, n_settings);
    $display("status results: ok %0d, crc mismatch %0d, short %0d, truncated %0d, too large %0d",
             stat_seen[ST_OK], stat_seen[ST_MISMATCH], stat_seen[ST_SHORT],
             stat_seen[ST_TRUNC], stat_seen[ST_TOOBIG]);
    if (n_mismatch == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
